// ----- design/clbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clbc_pkg: shared types and constants
// Payload structs, code values, register map and the init command table
// for the character LCD bus controller.
// ----------------------------------------------------------------------------
package clbc_pkg;

    // Position of the busy flag in a returned status byte
    localparam int BUSY_BIT_POS = 7;

    // Input command codes
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_REQ    = 2'd1;
    localparam logic [1:0] CMD_STATUS = 2'd2;

    // Bus actions
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Outcome codes
    localparam logic [1:0] OUT_NOTHING  = 2'd0;
    localparam logic [1:0] OUT_DONE     = 2'd1;
    localparam logic [1:0] OUT_TIMEOUT  = 2'd2;
    localparam logic [1:0] OUT_REJECTED = 2'd3;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_BUSY_TIMEOUT = 3'd0;
    localparam logic [2:0] REG_POWER_WAIT   = 3'd1;
    localparam logic [2:0] REG_SECOND_WAIT  = 3'd2;
    localparam logic [2:0] REG_THIRD_WAIT   = 3'd3;
    localparam logic [2:0] REG_CLEAR_READS  = 3'd4;

    localparam int ADDR_W = 5;

    // Register reset values
    localparam logic [15:0] RST_BUSY_TIMEOUT = 16'd1001;
    localparam logic [15:0] RST_POWER_WAIT   = 16'd1501;
    localparam logic [15:0] RST_SECOND_WAIT  = 16'd411;
    localparam logic [15:0] RST_THIRD_WAIT   = 16'd11;
    localparam logic [1:0]  RST_CLEAR_READS  = 2'd2;

    localparam logic [7:0]  FUNC_SET_BYTE = 8'h3A;
    localparam logic [2:0]  INIT_STEPS    = 3'd6;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_WAIT1,
        PH_WAIT2,
        PH_WAIT3,
        PH_INIT_POLL,
        PH_IDLE,
        PH_HOST_POLL
    } phase_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       req_is_data;
        logic [7:0] req_byte;
        logic [7:0] status_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] bus_op;
        logic       bus_rs;
        logic [7:0] bus_byte;
        logic [1:0] outcome;
        logic       idle;
        logic       error_seen;
    } out_item_t;

    typedef struct packed {
        logic [15:0] busy_timeout_ticks;
        logic [15:0] power_on_wait_ticks;
        logic [15:0] second_wait_ticks;
        logic [15:0] third_wait_ticks;
        logic [1:0]  clear_reads_needed;
    } cfg_t;

    // Init command sequence sent after the three raw function-set writes
    function automatic logic [7:0] init_cmd(input logic [2:0] step);
        logic [7:0] b;
        case (step)
            3'd0:    b = 8'h3A;
            3'd1:    b = 8'h08;
            3'd2:    b = 8'h01;
            3'd3:    b = 8'h02;
            3'd4:    b = 8'h06;
            3'd5:    b = 8'h0E;
            default: b = 8'h3A;
        endcase
        return b;
    endfunction

endpackage

// ----- design/clbc_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clbc_regs: configuration register file
// APB-style slave holding the timing and polling settings. Zero wait
// states; writes land on the access phase.
// ----------------------------------------------------------------------------
module clbc_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [clbc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output clbc_pkg::cfg_t            cfg
);
    import clbc_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.busy_timeout_ticks  <= RST_BUSY_TIMEOUT;
            cfg_reg.power_on_wait_ticks <= RST_POWER_WAIT;
            cfg_reg.second_wait_ticks   <= RST_SECOND_WAIT;
            cfg_reg.third_wait_ticks    <= RST_THIRD_WAIT;
            cfg_reg.clear_reads_needed  <= RST_CLEAR_READS;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_BUSY_TIMEOUT: cfg_reg.busy_timeout_ticks  <= pwdata[15:0];
                REG_POWER_WAIT:   cfg_reg.power_on_wait_ticks <= pwdata[15:0];
                REG_SECOND_WAIT:  cfg_reg.second_wait_ticks   <= pwdata[15:0];
                REG_THIRD_WAIT:   cfg_reg.third_wait_ticks    <= pwdata[15:0];
                REG_CLEAR_READS:  cfg_reg.clear_reads_needed  <= pwdata[1:0];
                default:          ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_BUSY_TIMEOUT: prdata = {16'd0, cfg_reg.busy_timeout_ticks};
            REG_POWER_WAIT:   prdata = {16'd0, cfg_reg.power_on_wait_ticks};
            REG_SECOND_WAIT:  prdata = {16'd0, cfg_reg.second_wait_ticks};
            REG_THIRD_WAIT:   prdata = {16'd0, cfg_reg.third_wait_ticks};
            REG_CLEAR_READS:  prdata = {30'd0, cfg_reg.clear_reads_needed};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// ----- design/char_lcd_bus_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_bus_controller: 8-bit character LCD bus controller
// Power-on sequence, busy polling and host byte writes for an
// HD44780-style display.
// ----------------------------------------------------------------------------
// Each input request (a 10 us tick, a host write request or a returned
// status byte) produces exactly one result in the cycle after it is accepted,
// and a new request can be taken every cycle: the state machine updates in
// a single pass from the accepted request into the result register. The
// only back-pressure is a result still waiting in that register while the
// downstream side holds ready low. After reset the block runs the power-on
// waits, three raw 0x3A writes and six init commands, all driven by the
// ticks and status bytes it is fed; idle in the result goes high once
// that has finished. Change settings through the APB port only while idle;
// the block itself does not enforce this.
module char_lcd_bus_controller (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  clbc_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output clbc_pkg::out_item_t         out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [clbc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import clbc_pkg::*;

    cfg_t cfg;

    clbc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // State
    phase_t      phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [1:0]  crc_reg, crc_next;
    logic        pend_rs_reg, pend_rs_next;
    logic [7:0]  pend_byte_reg, pend_byte_next;
    logic [2:0]  step_reg, step_next;
    logic        err_reg, err_next;
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    out_item_t   res;

    logic        accept;
    logic [15:0] tick_inc;
    logic [15:0] wait_lim;
    logic [1:0]  crc_upd;
    logic [1:0]  need;
    logic        polling;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign tick_inc = (tick_reg == TICK_MAX) ? TICK_MAX : tick_reg + 16'd1;
    assign polling  = (phase_reg == PH_INIT_POLL) || (phase_reg == PH_HOST_POLL);
    assign need     = (cfg.clear_reads_needed == 2'd0) ? 2'd1 : cfg.clear_reads_needed;

    // Clear-read count after this status byte: busy restarts, else saturating
    always_comb
    begin
        if (in_data.status_byte[BUSY_BIT_POS])
            crc_upd = 2'd0;
        else if (crc_reg == 2'd3)
            crc_upd = 2'd3;
        else
            crc_upd = crc_reg + 2'd1;
    end

    // Wait limit for the current power-on phase
    always_comb
    begin
        case (phase_reg)
            PH_WAIT1: wait_lim = cfg.power_on_wait_ticks;
            PH_WAIT2: wait_lim = cfg.second_wait_ticks;
            default:  wait_lim = cfg.third_wait_ticks;
        endcase
    end

    // Next state and result
    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        crc_next       = crc_reg;
        pend_rs_next   = pend_rs_reg;
        pend_byte_next = pend_byte_reg;
        step_next      = step_reg;
        err_next       = err_reg;
        res            = '0;

        if (accept)
        begin
            case (in_data.cmd)
                CMD_TICK:
                begin
                    if (phase_reg == PH_WAIT1 || phase_reg == PH_WAIT2 ||
                        phase_reg == PH_WAIT3)
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= wait_lim)
                        begin
                            res.bus_op   = OP_WRITE;
                            res.bus_byte = FUNC_SET_BYTE;
                            tick_next    = 16'd0;
                            case (phase_reg)
                                PH_WAIT1: phase_next = PH_WAIT2;
                                PH_WAIT2: phase_next = PH_WAIT3;
                                default:
                                begin
                                    step_next  = 3'd0;
                                    crc_next   = 2'd0;
                                    phase_next = PH_INIT_POLL;
                                end
                            endcase
                        end
                    end
                    else if (polling)
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= cfg.busy_timeout_ticks)
                        begin
                            err_next    = 1'b1;
                            res.outcome = OUT_TIMEOUT;
                            phase_next  = PH_IDLE;
                            tick_next   = 16'd0;
                            crc_next    = 2'd0;
                        end
                        else
                            res.bus_op = OP_READ;
                    end
                end
                CMD_REQ:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        pend_rs_next   = in_data.req_is_data;
                        pend_byte_next = in_data.req_byte;
                        phase_next     = PH_HOST_POLL;
                        tick_next      = 16'd0;
                        crc_next       = 2'd0;
                        res.bus_op     = OP_READ;
                    end
                    else
                        res.outcome = OUT_REJECTED;
                end
                CMD_STATUS:
                begin
                    if (polling)
                    begin
                        crc_next = crc_upd;
                        if (crc_upd >= need)
                        begin
                            res.bus_op = OP_WRITE;
                            tick_next  = 16'd0;
                            crc_next   = 2'd0;
                            if (phase_reg == PH_HOST_POLL)
                            begin
                                res.bus_rs   = pend_rs_reg;
                                res.bus_byte = pend_byte_reg;
                                res.outcome  = OUT_DONE;
                                phase_next   = PH_IDLE;
                            end
                            else
                            begin
                                res.bus_byte = init_cmd(step_reg);
                                if (step_reg + 3'd1 >= INIT_STEPS)
                                begin
                                    step_next  = 3'd0;
                                    phase_next = PH_IDLE;
                                end
                                else
                                    step_next = step_reg + 3'd1;
                            end
                        end
                        else
                            res.bus_op = OP_READ;
                    end
                end
                default: ;
            endcase
        end

        res.idle       = (phase_next == PH_IDLE);
        res.error_seen = err_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT1;
            tick_reg      <= 16'd0;
            crc_reg       <= 2'd0;
            pend_rs_reg   <= 1'b0;
            pend_byte_reg <= 8'd0;
            step_reg      <= 3'd0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            crc_reg       <= crc_next;
            pend_rs_reg   <= pend_rs_next;
            pend_byte_reg <= pend_byte_next;
            step_reg      <= step_next;
            err_reg       <= err_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= res;
    end

endmodule

// ----- design/clbc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clbc_checker: port-level checks
// Watches the request and result channels of the bus controller.
// ----------------------------------------------------------------------------
module clbc_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  clbc_pkg::out_item_t out_data
);
    import clbc_pkg::*;

    // Every accepted request gives a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("no result after accepted request");

    // An empty result register never holds off requests
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request stalled with empty result register");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Error flag is sticky across results
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_seen |=> !out_valid || out_data.error_seen)
        else $error("error flag cleared");

endmodule

bind char_lcd_bus_controller clbc_checker u_clbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
